// ===== design/bsmsu_pkg.sv =====
// Package: operation codes, field widths and binary64 constants for the sign/minmax/scale unit.
package bsmsu_pkg;

    typedef enum logic [2:0] {
        ACT_COPYSIGN = 3'd0,
        ACT_MAX      = 3'd1,
        ACT_MIN      = 3'd2,
        ACT_NEXT     = 3'd3,
        ACT_SPLIT    = 3'd4,
        ACT_SCALE    = 3'd5
    } action_t;

    localparam logic [63:0] MAG_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
    localparam logic [63:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] KEEP_MASK = 64'h800F_FFFF_FFFF_FFFF;
    localparam logic [63:0] HALF_EXP  = 64'h3FE0_0000_0000_0000;
    localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] POS_INF   = 64'h7FF0_0000_0000_0000;
    localparam logic signed [11:0] SPLIT_BIAS = 12'sd1022;
    localparam logic signed [13:0] EXP_ALL    = 14'sd2047;

    typedef struct packed {
        logic signed [12:0] scale;
        logic [63:0]        y_bits;
        logic [63:0]        x_bits;
        logic [2:0]         action;
    } op_t;

    typedef struct packed {
        logic signed [11:0] exponent_out;
        logic [63:0]        result_bits;
    } res_t;

endpackage

// ===== design/bsmsu_core.sv =====
// Combinational datapath: computes one result from one registered operation.
module bsmsu_core
    import bsmsu_pkg::*;
(
    input  op_t  op,
    output res_t res
);

    logic [63:0] x, y;
    logic x_nan, y_nan, x_zero, y_zero, x_inf;
    logic [63:0] kx, ky;
    logic x_lt_y, y_lt_x;
    logic [10:0] field;
    logic signed [13:0] e_sum;
    logic away;

    always_comb begin
        x = op.x_bits;
        y = op.y_bits;
        x_nan  = ((x & EXP_MASK) == EXP_MASK) && ((x & FRAC_MASK) != 64'd0);
        y_nan  = ((y & EXP_MASK) == EXP_MASK) && ((y & FRAC_MASK) != 64'd0);
        x_zero = (x & MAG_MASK) == 64'd0;
        y_zero = (y & MAG_MASK) == 64'd0;
        x_inf  = (x & MAG_MASK) == POS_INF;
        // monotone keys: negative patterns invert, positive ones set the top bit
        kx = x[63] ? ~x : (x | SIGN_MASK);
        ky = y[63] ? ~y : (y | SIGN_MASK);
        x_lt_y = !(x_zero && y_zero) && (kx < ky);
        y_lt_x = !(x_zero && y_zero) && (ky < kx);
        field = x[62:52];
        e_sum = $signed({3'b000, field}) + 14'(op.scale);
        away  = x[63] ? y_lt_x : x_lt_y;

        res.result_bits  = 64'd0;
        res.exponent_out = 12'sd0;
        case (op.action)
            ACT_COPYSIGN: res.result_bits = (x & MAG_MASK) | (y & SIGN_MASK);
            ACT_MAX: begin
                if (x_nan)      res.result_bits = y;
                else if (y_nan) res.result_bits = x;
                else            res.result_bits = y_lt_x ? x : y;
            end
            ACT_MIN: begin
                if (x_nan)      res.result_bits = y;
                else if (y_nan) res.result_bits = x;
                else            res.result_bits = x_lt_y ? x : y;
            end
            ACT_NEXT: begin
                if (x_nan || y_nan)         res.result_bits = QNAN_BITS;
                else if (!x_lt_y && !y_lt_x) res.result_bits = y;
                else if (x_zero)            res.result_bits = (y & SIGN_MASK) | 64'd1;
                else if (away)              res.result_bits = x + 64'd1;
                else                        res.result_bits = x - 64'd1;
            end
            ACT_SPLIT: begin
                if (x_zero || x_nan || x_inf) begin
                    res.result_bits = x;
                end else begin
                    res.exponent_out = $signed({1'b0, field}) - SPLIT_BIAS;
                    res.result_bits  = (x & KEEP_MASK) | HALF_EXP;
                end
            end
            ACT_SCALE: begin
                if (x_zero || x_nan || x_inf)  res.result_bits = x;
                else if (e_sum >= EXP_ALL)     res.result_bits = (x & SIGN_MASK) | POS_INF;
                else if (e_sum <= 14'sd0)      res.result_bits = 64'd0;
                else res.result_bits = (x & KEEP_MASK) | {1'b0, e_sum[10:0], 52'd0};
            end
            default: res.result_bits = 64'd0;
        endcase
    end

endmodule

// ===== design/binary64_sign_minmax_scale_unit_top.sv =====
// Top level: input register, datapath and output register with stream handshakes.
//
//  channel | dir | tdata bits (low first)                          | tuser
//  s_      | in  | action[2:0] x_bits[66:3] y_bits[130:67] scale[143:131] | -
//  m_      | out | result_bits[63:0] exponent_out[75:64]           | -
//
// One transaction per cycle while the m_ side is not stalled; path: input register, result register.
// The result register is refilled whenever it is empty or being taken.
// Reset clears both valid flags; a stalled m_ side holds both stages.
module binary64_sign_minmax_scale_unit_top
    import bsmsu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // action, x_bits, y_bits, scale
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata    // result_bits, exponent_out, zero pad
);

    op_t  op_reg;
    logic op_valid_reg;
    res_t res_reg, res_next;
    logic res_valid_reg;
    logic adv;

    assign adv      = !res_valid_reg || m_tready;
    assign s_tready = adv;

    bsmsu_core u_core (.op(op_reg), .res(res_next));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else if (adv) begin
            op_valid_reg  <= s_tvalid;
            res_valid_reg <= op_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_reg  <= s_tdata;
            res_reg <= res_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {4'd0, res_reg.exponent_out, res_reg.result_bits};

endmodule

// ===== design/bsmsu_checker.sv =====
// Port checker for the sign/minmax/scale unit, bound to the top level.
module bsmsu_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [79:0]  m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 s_tready |=> m_tvalid)
        else $error("accepted transaction did not arrive");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[79:76] == 4'd0)
        else $error("pad bits nonzero");

endmodule

bind binary64_sign_minmax_scale_unit_top bsmsu_checker u_chk (.*);
